### sv/ppv3_pkg.sv
`default_nettype none

package ppv3_pkg;

  // Fixed widths of the transaction fields
  localparam int FIELD_BITS     = 32;
  localparam int VEL_BITS       = 48;
  localparam int VEL_FRAC       = 8;
  localparam int COORD_BITS_DEF = 32;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DT = 2'd1;
  localparam logic [1:0] STATUS_SAT     = 2'd2;

  // Saturation limits of the signed Q40.8 velocity
  localparam logic [VEL_BITS-1:0] VEL_MAX_POS = {1'b0, {(VEL_BITS-1){1'b1}}};
  localparam logic [VEL_BITS-1:0] VEL_MIN_NEG = {1'b1, {(VEL_BITS-1){1'b0}}};

  typedef struct packed {
    logic                         path_start;
    logic signed [FIELD_BITS-1:0] x_coord;
    logic signed [FIELD_BITS-1:0] y_coord;
    logic signed [FIELD_BITS-1:0] z_coord;
    logic        [FIELD_BITS-1:0] timestamp;
  } point_t;

  typedef struct packed {
    logic signed [VEL_BITS-1:0] velocity;
    logic        [1:0]          status;
  } result_t;

endpackage

`default_nettype wire

### sv/point_pair_velocity_3d.sv
// Flow: a first point (or path start) is stored with no result; a zero time step goes
//   straight to the result state, and any other point first runs the squares, root and
//   divide. A new point is taken only in the idle state, after the last result is loaded;
//   the result waits while the output stalls. One shared add/subtract unit runs squares,
//   root and divide in turn.
// Reset (synchronous, active high) clears the stored point, drops any pending result.
`default_nettype none

module point_pair_velocity_3d #(
  parameter int COORD_BITS = ppv3_pkg::COORD_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              point_valid,
  output logic                   point_stall,
  input  wire ppv3_pkg::point_t  point,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output ppv3_pkg::result_t      result
);

  import ppv3_pkg::*;

  // Derived widths
  localparam int DW  = COORD_BITS + 1;         // magnitude of a coordinate difference
  localparam int SW  = 2 * COORD_BITS + 2;     // sum of three squares, also the adder width
  localparam int RW  = SW + 2 * VEL_FRAC;      // radicand in Q.16
  localparam int QW  = RW / 2;                 // root and quotient
  localparam int CW  = $clog2(QW);
  localparam int TW  = FIELD_BITS;             // time step magnitude
  localparam int MW  = QW + VEL_BITS;          // magnitude compare width
  localparam int NUM_AXES = 3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_SQ   = 6'b000100,
    ST_ROOT = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                  state;
  logic                    have_prev;
  logic [COORD_BITS-1:0]   prev_x, prev_y, prev_z;
  logic [COORD_BITS-1:0]   cur_x, cur_y, cur_z;
  logic [TW-1:0]           prev_t;
  logic [TW-1:0]           adt;
  logic                    dt_neg;
  logic                    dt_zero;
  logic [1:0]              axis;
  logic [CW-1:0]           cnt;
  logic [SW-1:0]           mcand;
  logic [DW-1:0]           mplier;
  logic [SW-1:0]           acc;
  logic [RW-1:0]           rad;
  logic [QW+1:0]           rem;
  logic [QW-1:0]           root;
  logic [TW:0]             drem;

  logic                    point_take;
  logic                    result_take;
  logic                    result_free;
  logic [COORD_BITS-1:0]   in_x, in_y, in_z;
  logic [TW:0]             dtw;
  logic [COORD_BITS:0]     diff;
  logic [DW-1:0]           ad;
  logic [QW+1:0]           root_r2;
  logic [TW:0]             div_r2;
  logic [SW-1:0]           add_a, add_b;
  logic                    add_sub;
  logic [SW:0]             add_y;
  logic                    borrow;
  logic [MW-1:0]           magx;
  result_t                 res_next;

  assign point_take  = point_valid && !point_stall;
  assign result_take = result_valid && !result_stall;
  assign result_free = !result_valid || !result_stall;
  assign point_stall = (state != ST_IDLE);

  // Narrow or widen the coordinates to the working width
  assign in_x = COORD_BITS'(point.x_coord);
  assign in_y = COORD_BITS'(point.y_coord);
  assign in_z = COORD_BITS'(point.z_coord);

  // Signed 33-bit time step
  assign dtw = {1'b0, point.timestamp} - {1'b0, prev_t};

  // Absolute coordinate difference of the current axis
  always_comb begin
    case (axis)
      AXIS_X:  diff = {cur_x[COORD_BITS-1], cur_x} - {prev_x[COORD_BITS-1], prev_x};
      AXIS_Y:  diff = {cur_y[COORD_BITS-1], cur_y} - {prev_y[COORD_BITS-1], prev_y};
      default: diff = {cur_z[COORD_BITS-1], cur_z} - {prev_z[COORD_BITS-1], prev_z};
    endcase
    ad = diff[COORD_BITS] ? (~diff + 1'b1) : diff;
  end

  // Trial values of the square root and divide steps
  assign root_r2 = {rem[QW-1:0], rad[RW-1 -: 2]};
  assign div_r2  = {drem[TW-1:0], root[QW-1]};

  // Shared add/subtract unit
  always_comb begin
    add_a   = acc;
    add_b   = mplier[0] ? mcand : '0;
    add_sub = 1'b0;
    unique case (state)
      ST_ROOT: begin
        add_a   = SW'(root_r2);
        add_b   = SW'({root, 2'b01});
        add_sub = 1'b1;
      end
      ST_DIV: begin
        add_a   = SW'(div_r2);
        add_b   = SW'({1'b0, adt});
        add_sub = 1'b1;
      end
      default: begin
        add_a   = acc;
        add_b   = mplier[0] ? mcand : '0;
        add_sub = 1'b0;
      end
    endcase
    add_y = {1'b0, add_a} + (add_sub ? ~{1'b0, add_b} : {1'b0, add_b}) + (SW+1)'(add_sub);
  end

  assign borrow = add_y[SW];

  // Saturate and sign the quotient
  always_comb begin
    magx = MW'(root);
    res_next.velocity = '0;
    res_next.status   = STATUS_OK;
    if (dt_zero) begin
      res_next.status = STATUS_ZERO_DT;
    end else if (!dt_neg) begin
      if (magx > MW'(VEL_MAX_POS)) begin
        res_next.velocity = VEL_MAX_POS;
        res_next.status   = STATUS_SAT;
      end else begin
        res_next.velocity = VEL_BITS'(root);
      end
    end else begin
      if (magx > MW'(VEL_MIN_NEG)) begin
        res_next.velocity = VEL_MIN_NEG;
        res_next.status   = STATUS_SAT;
      end else begin
        res_next.velocity = ~VEL_BITS'(root) + 1'b1;
      end
    end
  end

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      have_prev    <= 1'b0;
      prev_x       <= '0;
      prev_y       <= '0;
      prev_z       <= '0;
      prev_t       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_take && state != ST_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (point_take) begin
            prev_t    <= point.timestamp;
            have_prev <= 1'b1;
            dt_neg    <= dtw[TW];
            adt       <= dtw[TW] ? TW'(~dtw + 1'b1) : dtw[TW-1:0];
            dt_zero   <= (dtw == '0);
            cur_x     <= in_x;
            cur_y     <= in_y;
            cur_z     <= in_z;
            axis      <= AXIS_X;
            acc       <= '0;
            if (point.path_start || !have_prev || dtw == '0) begin
              // store the point at once
              prev_x <= in_x;
              prev_y <= in_y;
              prev_z <= in_z;
              if (!point.path_start && have_prev) begin
                state <= ST_DONE;
              end
            end else begin
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          mcand  <= SW'(ad);
          mplier <= ad;
          cnt    <= '0;
          state  <= ST_SQ;
        end
        ST_SQ: begin
          // one multiplier bit a cycle
          acc    <= add_y[SW-1:0];
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          if (cnt == CW'(DW - 1)) begin
            if (axis == 2'(NUM_AXES - 1)) begin
              rad    <= {add_y[SW-1:0], {(2*VEL_FRAC){1'b0}}};
              rem    <= '0;
              root   <= '0;
              cnt    <= '0;
              prev_x <= cur_x;
              prev_y <= cur_y;
              prev_z <= cur_z;
              state  <= ST_ROOT;
            end else begin
              axis  <= axis + 1'b1;
              state <= ST_LOAD;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_ROOT: begin
          // one root bit a cycle
          rad  <= rad << 2;
          rem  <= borrow ? root_r2 : add_y[QW+1:0];
          root <= {root[QW-2:0], ~borrow};
          if (cnt == CW'(QW - 1)) begin
            cnt   <= '0;
            drem  <= '0;
            state <= ST_DIV;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DIV: begin
          // one quotient bit a cycle, dividend shifted out of root
          drem <= borrow ? div_r2 : add_y[TW:0];
          root <= {root[QW-2:0], ~borrow};
          cnt  <= cnt + 1'b1;
          if (cnt == CW'(QW - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (result_free) begin
            result       <= res_next;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Saturated results carry a limit value
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_SAT) |->
      (result.velocity == VEL_MAX_POS || result.velocity == VEL_MIN_NEG))
    else $error("saturated result without limit velocity");

  // Zero time step yields zero velocity
  a_zero_dt: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STATUS_ZERO_DT) |-> (result.velocity == '0))
    else $error("zero time step with non-zero velocity");

  // A path start produces no work
  a_path_start: assert property (@(posedge clk) disable iff (rst)
    (point_take && point.path_start) |=> (state == ST_IDLE))
    else $error("path start point entered the datapath");

  // Step counter stays within the root and quotient width
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROOT || state == ST_DIV) |-> (cnt <= CW'(QW - 1)))
    else $error("step counter out of range");

  // A result is loaded only from the final state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> ($past(state) == ST_DONE))
    else $error("result raised outside the final state");

endmodule

`default_nettype wire
